>>> hw/rtl/ppolar_pkg.sv
package ppolar_pkg;

    localparam int COORD_BITS   = 20;
    localparam int RMIN_BITS    = 19;
    localparam int RSQ_BITS     = 2 * COORD_BITS;
    localparam int INT_BITS     = 16;
    localparam int SEL_BITS     = 9;
    localparam int ROOT_BITS    = 20;
    localparam int CORDIC_ITERS = 20;
    localparam int SQRT_ITERS   = RSQ_BITS / 2;

    // Angles are in units of 2^-16 degree.
    localparam int DEG90   = 90 * 65536;
    localparam int DEG180  = 180 * 65536;
    localparam int ANG_LIM = 179 * 65536;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic                         command;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         point_invalid;
        logic [INT_BITS-1:0]          point_intensity;
        logic [SEL_BITS-1:0]          bin_select;
    } t_in_item;

    typedef struct packed {
        logic [SEL_BITS-1:0]  bin_index;
        logic [ROOT_BITS-1:0] range_mm;
        logic [INT_BITS-1:0]  bin_intensity;
        logic                 bin_empty;
    } t_out_item;

    typedef struct packed {
        logic                filled;
        logic [RSQ_BITS-1:0] rsq;
        logic [INT_BITS-1:0] intensity;
    } t_bin;

    // atan(2^-i) in 2^-16 degree, rounded.
    function automatic logic [21:0] f_atan(input logic [4:0] i);
        logic [21:0] v;
        unique case (i)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234378;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/point_to_polar_min_range_bins.sv
// Channel   Direction  Handshake                  Payload
// -------   ---------  ---------                  -------
// input     in         i_in_valid / o_in_stall    i_in  (ppolar_pkg::t_in_item)
// output    out        o_out_valid / i_out_stall  o_out (ppolar_pkg::t_out_item)
// config    in         i_cfg_wr_en                i_cfg_wr_data (minimum range)
//
// Requests are served one at a time. An add request stalls the input through preparation,
// range check, 20 CORDIC steps on one shared rotator, angle mapping and the bin update.
// A point on an axis skips the rotator; a dropped point frees the input without a bin update.
// A read request gives its result after read and clear, 20 root digits and the result register,
// and stalls the input until then, or longer while an earlier result waits.
// After reset a clearing pass over every bin empties the bin memory with the input stalled.
module point_to_polar_min_range_bins #(
    parameter int NUM_BINS = 358
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  ppolar_pkg::t_in_item                i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output ppolar_pkg::t_out_item               o_out,
    input  logic                                i_cfg_wr_en,
    input  logic [ppolar_pkg::RMIN_BITS-1:0]    i_cfg_wr_data
);
    import ppolar_pkg::*;

    localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(NUM_BINS - 1);

    // Sequencer states.
    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_PREP = 4'd2;
    localparam logic [3:0] ST_CHK  = 4'd3;
    localparam logic [3:0] ST_CORD = 4'd4;
    localparam logic [3:0] ST_MAP  = 4'd5;
    localparam logic [3:0] ST_UPD  = 4'd6;
    localparam logic [3:0] ST_RDW  = 4'd7;
    localparam logic [3:0] ST_SQRT = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    logic [3:0]  r_state;
    logic [3:0]  n_state;

    // The bin store: one word per bin holding the filled flag, the nearest
    // squared range and its intensity.
    t_bin             r_bins [NUM_BINS];
    t_bin             r_rdata;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    t_bin             mem_wr_data;

    logic [RMIN_BITS-1:0]  r_min_range;
    logic [IDX_W-1:0]      r_clr_cnt;
    t_in_item              r_item;
    logic [COORD_BITS-1:0] r_ax;
    logic [COORD_BITS-1:0] r_ay;
    logic [RSQ_BITS-1:0]   r_sqx;
    logic [RSQ_BITS-1:0]   r_sqy;
    logic [2*RMIN_BITS-1:0] r_rmin2;
    logic [RSQ_BITS-1:0]   r_rsq;
    logic signed [31:0]    r_cx;
    logic signed [31:0]    r_cy;
    logic signed [24:0]    r_cz;
    logic [4:0]            r_cnt;
    logic [IDX_W-1:0]      r_bin;
    logic [RSQ_BITS-1:0]   r_val;
    logic [23:0]           r_rem;
    logic [ROOT_BITS-1:0]  r_root;
    logic [INT_BITS-1:0]   r_res_int;
    logic                  r_res_empty;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  in_accept;
    logic                  sel_ok;
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [RSQ_BITS-1:0]   rsq_sum;
    logic signed [31:0]    xs;
    logic signed [31:0]    ys;
    logic signed [24:0]    atan_s;
    logic signed [24:0]    zc;
    logic signed [24:0]    ang;
    logic signed [25:0]    ang_ofs;
    logic [SEL_BITS-1:0]   idx9;
    logic                  ang_bad;
    logic [23:0]           rem_sh;
    logic [23:0]           trial;
    logic                  load_out;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign sel_ok      = (32'(r_item.bin_select) < NUM_BINS);
    assign load_out    = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);

    // Magnitudes of the coordinates; the most negative value maps to 2^19.
    assign ax = r_item.point_x[COORD_BITS-1] ? (~r_item.point_x + 1'b1) : r_item.point_x;
    assign ay = r_item.point_y[COORD_BITS-1] ? (~r_item.point_y + 1'b1) : r_item.point_y;
    assign rsq_sum = r_sqx + r_sqy;

    // One CORDIC vectoring step on the shared rotator.
    assign xs     = r_cx >>> r_cnt;
    assign ys     = r_cy >>> r_cnt;
    assign atan_s = 25'(f_atan(r_cnt));

    // Angle mapping: clamp to the first quadrant, reflect to the true
    // quadrant, reject beyond plus or minus 179 degrees and pick the bin.
    always_comb begin
        if (r_cz < 0) begin
            zc = '0;
        end else if (r_cz > 25'(DEG90)) begin
            zc = 25'(DEG90);
        end else begin
            zc = r_cz;
        end
        ang = r_item.point_x[COORD_BITS-1] ? (25'(DEG180) - zc) : zc;
        if (r_item.point_y[COORD_BITS-1]) begin
            ang = -ang;
        end
        ang_bad = (ang < -25'(ANG_LIM)) || (ang > 25'(ANG_LIM));
        ang_ofs = 26'(ang) + 26'(ANG_LIM);
        idx9    = ang_ofs[24:16];
    end

    // One digit of the square root.
    assign rem_sh = {r_rem[21:0], r_val[RSQ_BITS-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};

    always_comb begin
        n_state     = r_state;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = '0;
        unique case (r_state)
            ST_CLR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_clr_cnt;
                if (r_clr_cnt == LAST_BIN) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                if (r_item.command == CMD_READ) begin
                    mem_rd_en   = sel_ok;
                    mem_rd_addr = IDX_W'(r_item.bin_select);
                    n_state     = ST_RDW;
                end else begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (r_item.point_invalid || (rsq_sum < RSQ_BITS'(r_rmin2))) begin
                    n_state = ST_IDLE;
                end else if (r_ay == '0 || r_ax == '0) begin
                    n_state = ST_MAP;
                end else begin
                    n_state = ST_CORD;
                end
            end
            ST_CORD: begin
                if (r_cnt == 5'(CORDIC_ITERS - 1)) begin
                    n_state = ST_MAP;
                end
            end
            ST_MAP: begin
                if (ang_bad) begin
                    n_state = ST_IDLE;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = (32'(idx9) > NUM_BINS - 1) ? LAST_BIN : IDX_W'(idx9);
                    n_state     = ST_UPD;
                end
            end
            ST_UPD: begin
                if (!r_rdata.filled || (r_rsq < r_rdata.rsq)) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_bin;
                    mem_wr_data = '{filled: 1'b1, rsq: r_rsq,
                                    intensity: r_item.point_intensity};
                end
                n_state = ST_IDLE;
            end
            ST_RDW: begin
                mem_wr_en   = sel_ok;
                mem_wr_addr = IDX_W'(r_item.bin_select);
                n_state     = ST_SQRT;
            end
            ST_SQRT: begin
                if (r_cnt == 5'(SQRT_ITERS - 1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_bins[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rdata <= r_bins[mem_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr_cnt   <= '0;
            r_min_range <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cfg_wr_en) begin
                r_min_range <= i_cfg_wr_data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in;
        end
        if (r_state == ST_PREP) begin
            r_ax    <= ax;
            r_ay    <= ay;
            r_sqx   <= RSQ_BITS'(ax) * RSQ_BITS'(ax);
            r_sqy   <= RSQ_BITS'(ay) * RSQ_BITS'(ay);
            r_rmin2 <= (2*RMIN_BITS)'(r_min_range) * (2*RMIN_BITS)'(r_min_range);
        end
        if (r_state == ST_CHK) begin
            r_rsq <= rsq_sum;
            r_cx  <= 32'({r_ax, 8'h00});
            r_cy  <= 32'({r_ay, 8'h00});
            r_cnt <= '0;
            if (r_ay == '0) begin
                r_cz <= '0;
            end else if (r_ax == '0) begin
                r_cz <= 25'(DEG90);
            end else begin
                r_cz <= '0;
            end
        end
        if (r_state == ST_CORD) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cy > 0) begin
                r_cx <= r_cx + ys;
                r_cy <= r_cy - xs;
                r_cz <= r_cz + atan_s;
            end else if (r_cy < 0) begin
                r_cx <= r_cx - ys;
                r_cy <= r_cy + xs;
                r_cz <= r_cz - atan_s;
            end
        end
        if (r_state == ST_MAP) begin
            r_bin <= mem_rd_addr;
        end
        if (r_state == ST_RDW) begin
            r_val       <= (sel_ok && r_rdata.filled) ? r_rdata.rsq : '0;
            r_res_int   <= (sel_ok && r_rdata.filled) ? r_rdata.intensity : '0;
            r_res_empty <= !(sel_ok && r_rdata.filled);
            r_rem       <= '0;
            r_root      <= '0;
            r_cnt       <= '0;
        end
        if (r_state == ST_SQRT) begin
            r_cnt <= r_cnt + 1'b1;
            r_val <= {r_val[RSQ_BITS-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_BITS-2:0], 1'b0};
            end
        end
        if (load_out) begin
            r_out <= '{bin_index: r_item.bin_select, range_mm: r_root,
                       bin_intensity: r_res_int, bin_empty: r_res_empty};
        end
    end

    // A bin is never read and written in the same cycle.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_rd_en && mem_wr_en))
        else $error("bin memory read and written in one cycle");

    // Every accepted request starts in the preparation step.
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_PREP))
        else $error("accepted request did not enter preparation");

    // A result appears only from the result state.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("result valid rose outside the result state");

    // The root of any stored squared range fits the output range.
    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_root <= 20'd741455))
        else $error("square root beyond largest planar range");

endmodule

>>> sim/point_to_polar_min_range_bins_tb.sv
module point_to_polar_min_range_bins_tb;
    import ppolar_pkg::*;

    // Bin count of the instance and the quiet time that covers the slowest
    // request (an add keeps the input stalled through the rotator and returns nothing).
    localparam int N_BINS      = 358;
    localparam int SETTLE_CYC  = 60;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYC    = 400;

    // Arctangent steps of the first-quadrant rotator, 2^-16 degree units.
    localparam longint ATAN_STEP [20] = '{
        2949120, 1740967, 919879, 466945, 234378, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out;
    logic                 i_cfg_wr_en = 1'b0;
    logic [RMIN_BITS-1:0] i_cfg_wr_data = '0;

    point_to_polar_min_range_bins #(.NUM_BINS(N_BINS)) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in         (i_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out        (o_out),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the scan: nearest squared range, its intensity and
    // whether the bin holds a point at all.
    longint unsigned scan_rsq [N_BINS];
    logic [15:0]     scan_intensity [N_BINS];
    bit              scan_filled [N_BINS];
    longint unsigned min_range_mm;
    int              last_hit_bin;

    // Read results still to come back from the block, oldest first.
    t_out_item pending_reads [$];

    int  error_count;
    int  idle_cycles;
    bit  steady_flow;     // when set neither side idles
    int  hold_requests;   // bumped by a test to ask for a long output hold-off
    int  hold_seen;
    int  hold_left;

    function automatic bit roll_idle();
        return !steady_flow && ($urandom_range(99) < 31);
    endfunction

    // Angle of a first-quadrant point, 2^-16 degree, by vectoring rotations.
    function automatic longint quadrant_angle(longint ax, longint ay);
        longint x, y, z, xs, ys;
        z = 0;
        if (ay == 0) return 0;
        if (ax == 0) return DEG90;
        x = ax * 256;
        y = ay * 256;
        for (int i = 0; i < 20; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + ATAN_STEP[i];
            end else if (y < 0) begin
                x = x - ys; y = y + xs; z = z - ATAN_STEP[i];
            end
        end
        if (z < 0) z = 0;
        if (z > DEG90) z = DEG90;
        return z;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Applies one accepted request to the shadow scan and queues the read
    // result it produces, if any.
    task automatic apply_request(input t_in_item req);
        t_out_item       res;
        longint          px, py, ax, ay, ang;
        longint unsigned rsq, root;
        int              idx;
        if (req.command == CMD_READ) begin
            res = '0;
            res.bin_index = req.bin_select;
            res.bin_empty = 1'b1;
            if (req.bin_select < N_BINS) begin
                idx = req.bin_select;
                if (scan_filled[idx]) begin
                    root = floor_root(scan_rsq[idx]);
                    res.range_mm      = (root > 64'hFFFFF) ? 20'hFFFFF : root[19:0];
                    res.bin_intensity = scan_intensity[idx];
                    res.bin_empty     = 1'b0;
                end
                scan_filled[idx]    = 1'b0;
                scan_rsq[idx]       = 0;
                scan_intensity[idx] = '0;
            end
            pending_reads.push_back(res);
        end else if (!req.point_invalid) begin
            px  = req.point_x;
            py  = req.point_y;
            ax  = (px < 0) ? -px : px;
            ay  = (py < 0) ? -py : py;
            rsq = ax * ax + ay * ay;
            if (rsq >= min_range_mm * min_range_mm) begin
                ang = quadrant_angle(ax, ay);
                if (px < 0) ang = DEG180 - ang;
                if (py < 0) ang = -ang;
                if (ang >= -ANG_LIM && ang <= ANG_LIM) begin
                    idx = int'((ang + ANG_LIM) >>> 16);
                    if (idx > N_BINS - 1) idx = N_BINS - 1;
                    last_hit_bin = idx;
                    if (!scan_filled[idx] || rsq < scan_rsq[idx]) begin
                        scan_filled[idx]    = 1'b1;
                        scan_rsq[idx]       = rsq;
                        scan_intensity[idx] = req.point_intensity;
                    end
                end
            end
        end
    endtask

    // Offers one request, idling at random beforehand, and waits until it is
    // taken. Valid stays high afterwards so that back-to-back requests flow.
    task automatic send_request(input t_in_item req);
        while (roll_idle()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (o_in_stall);
        apply_request(req);
    endtask

    task automatic send_point(input logic signed [19:0] x, input logic signed [19:0] y,
                              input logic bad, input logic [15:0] inten);
        t_in_item req;
        req = '0;
        req.command         = CMD_ADD;
        req.point_x         = x;
        req.point_y         = y;
        req.point_invalid   = bad;
        req.point_intensity = inten;
        req.bin_select      = 9'($urandom);
        send_request(req);
    endtask

    task automatic send_read(input logic [8:0] sel);
        t_in_item req;
        req = '0;
        req.point_x         = 20'($urandom);
        req.point_y         = 20'($urandom);
        req.point_invalid   = 1'($urandom);
        req.point_intensity = 16'($urandom);
        req.command         = CMD_READ;
        req.bin_select      = sel;
        send_request(req);
    endtask

    // The register is only written once the block has drained; adds return
    // nothing, so a quiet spell follows the last read result.
    task automatic set_min_range(input logic [RMIN_BITS-1:0] v);
        i_in_valid <= 1'b0;
        wait (pending_reads.size() == 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        min_range_mm = v;
    endtask

    function automatic logic signed [19:0] rand_coord();
        case ($urandom_range(4))
            0: return 20'($urandom);
            1: return 20'($signed($urandom_range(4000)) - 2000);
            2: return 20'($signed($urandom_range(120000)) - 60000);
            3: return 20'($signed($urandom_range(2)) - 1);
            default: return 20'($signed($urandom_range(600)) - 300);
        endcase
    endfunction

    // Directed corners with the minimum range open: origin, the four half
    // axes, full-scale coordinates, dropped points, the clamp at +179 degrees
    // and reads of empty and non-existent bins.
    task automatic test_corners();
        set_min_range('0);
        send_point(20'sd0, 20'sd0, 1'b0, 16'hFFFF);        // origin, bin 179
        send_read(9'd179);
        send_point(20'sd1000, 20'sd0, 1'b0, 16'h0001);     // +x axis
        send_point(-20'sd1000, 20'sd0, 1'b0, 16'h1234);    // -x axis, dropped
        send_point(20'sd0, 20'sd777, 1'b0, 16'hA5A5);      // +90 degrees
        send_point(20'sd0, -20'sd777, 1'b0, 16'h5A5A);     // -90 degrees
        send_point(20'sd524287, 20'sd524287, 1'b0, 16'h0);
        send_point(-20'sd524288, -20'sd524288, 1'b0, 16'hFFFF);
        send_point(20'sd500, 20'sd500, 1'b1, 16'h7777);    // NaN point ignored
        send_point(-20'sd524288, 20'sd9150, 1'b0, 16'h00FF); // about +179
        send_point(-20'sd524288, -20'sd9150, 1'b0, 16'hFF00);// about -179
        send_point(-20'sd524288, 20'sd1, 1'b0, 16'h4321);  // just below 180
        send_read(9'd179);
        send_read(9'd269);
        send_read(9'd89);
        send_read(9'd224);
        send_read(9'd44);
        send_read(9'd357);
        send_read(9'd0);
        send_read(9'd358);                                 // beyond the scan
        send_read(9'd511);
        send_read(9'd100);                                 // empty bin
    endtask

    // Minimum range at its largest value and at a middling value.
    task automatic test_range_gate();
        set_min_range('1);
        send_point(20'sd524287, 20'sd0, 1'b0, 16'h1111);   // exactly at limit
        send_point(20'sd524286, 20'sd0, 1'b0, 16'h2222);   // just short
        send_point(-20'sd524288, -20'sd524288, 1'b0, 16'h3333);
        send_point(20'sd300000, 20'sd300000, 1'b0, 16'h4444);
        send_read(9'd179);
        send_read(9'd44);
        send_read(9'd224);
        set_min_range(19'd1000);
        send_point(20'sd999, 20'sd0, 1'b0, 16'h5555);
        send_point(20'sd600, 20'sd800, 1'b0, 16'h6666);
        send_point(20'sd0, 20'sd0, 1'b0, 16'h7777);
        send_read(9'd179);
        send_read(9'd232);
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 65) begin
                send_point(rand_coord(), rand_coord(), $urandom_range(99) < 10,
                           16'($urandom));
            end else if ($urandom_range(99) < 50) begin
                send_read(9'(last_hit_bin));
            end else if ($urandom_range(99) < 85) begin
                send_read(9'($urandom_range(N_BINS - 1)));
            end else begin
                send_read(9'($urandom_range(511, N_BINS)));
            end
        end
    endtask

    task automatic test_random();
        set_min_range(19'd0);
        run_random(130);
        set_min_range(19'($urandom_range(3000)));
        run_random(130);
        set_min_range(19'd50000);
        run_random(60);
    endtask

    // No idling on either side, then a long output hold-off so that the
    // result path and then the request side back up.
    task automatic test_pressure();
        set_min_range(19'd0);
        steady_flow = 1'b1;
        run_random(60);
        hold_requests++;
        for (int n = 0; n < 30; n++) send_read(9'($urandom_range(N_BINS - 1)));
        steady_flow = 1'b0;
    endtask

    // Output stall: random idling, or a counted hold-off on request.
    always @(posedge i_clk) begin
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYC;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= roll_idle();
        end
    end

    // Result checker and watchdog on the cycles in which nothing moves.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            idle_cycles = idle_cycles + 1;
            if (i_in_valid && !o_in_stall) idle_cycles = 0;
            if (o_out_valid && !i_out_stall) begin
                idle_cycles = 0;
                if (pending_reads.size() == 0) begin
                    $error("unexpected result for bin %0d", o_out.bin_index);
                    error_count++;
                end else begin
                    want = pending_reads.pop_front();
                    if (o_out.bin_index !== want.bin_index) begin
                        $error("bin_index: expected %0d, got %0d",
                               want.bin_index, o_out.bin_index);
                        error_count++;
                    end
                    if (o_out.range_mm !== want.range_mm) begin
                        $error("range_mm: expected %0d, got %0d",
                               want.range_mm, o_out.range_mm);
                        error_count++;
                    end
                    if (o_out.bin_intensity !== want.bin_intensity) begin
                        $error("bin_intensity: expected %0d, got %0d",
                               want.bin_intensity, o_out.bin_intensity);
                        error_count++;
                    end
                    if (o_out.bin_empty !== want.bin_empty) begin
                        $error("bin_empty: expected %0d, got %0d",
                               want.bin_empty, o_out.bin_empty);
                        error_count++;
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("point_to_polar_min_range_bins_tb failed");
                $finish;
            end
        end
    end

    initial begin
        error_count   = 0;
        idle_cycles   = 0;
        steady_flow   = 1'b0;
        hold_requests = 0;
        hold_seen     = 0;
        hold_left     = 0;
        min_range_mm  = 0;
        last_hit_bin  = 179;
        for (int b = 0; b < N_BINS; b++) begin
            scan_rsq[b]       = 0;
            scan_intensity[b] = '0;
            scan_filled[b]    = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corners();
        test_range_gate();
        test_random();
        test_pressure();

        i_in_valid <= 1'b0;
        wait (pending_reads.size() == 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (error_count == 0) begin
            $display("point_to_polar_min_range_bins_tb passed");
        end else begin
            $display("point_to_polar_min_range_bins_tb failed");
        end
        $finish;
    end

endmodule
